// File: rtl/hpt_pkg.sv
`default_nettype none

package hpt_pkg;

    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned ANGLE_W = 17;
    localparam int unsigned DRIVE_W = 8;
    localparam int unsigned ERR_W   = 9;
    localparam int unsigned SUM_W   = 12;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned ACC_W   = 30;

    // whole degrees
    localparam int signed HALF_TURN = 180;
    localparam int signed FULL_TURN = 360;
    localparam int signed SUM_LIMIT = 1200;
    // 120.0 in Q8.8
    localparam int signed DRIVE_LIMIT_Q = 30720;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P = 2'd0,
        CFG_GAIN_I = 2'd1,
        CFG_GAIN_D = 2'd2
    } cfg_sel_t;

    typedef struct packed {
        logic [GAIN_W-1:0] p;
        logic [GAIN_W-1:0] i;
        logic [GAIN_W-1:0] d;
    } gains_t;

endpackage

`default_nettype wire

// File: rtl/hpt_if.sv
`default_nettype none

interface hpt_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [hpt_pkg::ANGLE_W-1:0]       target_heading;
    logic signed [hpt_pkg::ANGLE_W-1:0]       yaw;

    modport source (output valid, output target_heading, output yaw, input ready);
    modport sink   (input valid, input target_heading, input yaw, output ready);
endinterface

interface hpt_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [hpt_pkg::DRIVE_W-1:0]       drive_left;
    logic signed [hpt_pkg::DRIVE_W-1:0]       drive_right;

    modport source (output valid, output drive_left, output drive_right, input ready);
    modport sink   (input valid, input drive_left, input drive_right, output ready);
endinterface

`default_nettype wire

// File: rtl/hpt_core.sv
`default_nettype none

module hpt_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  advance,
    input  wire logic signed [hpt_pkg::ANGLE_W-1:0]    target_heading,
    input  wire logic signed [hpt_pkg::ANGLE_W-1:0]    yaw,
    input  wire hpt_pkg::gains_t                       gains,
    output logic signed [hpt_pkg::DRIVE_W-1:0]         drive
);

    logic signed [hpt_pkg::ERR_W-1:0]   prior_reg;
    logic signed [hpt_pkg::ERR_W-1:0]   prior_next;
    logic signed [hpt_pkg::SUM_W-1:0]   sum_reg;
    logic signed [hpt_pkg::SUM_W-1:0]   sum_next;

    logic signed [17:0]                 diff;
    logic signed [17:0]                 diff_adj;
    logic signed [9:0]                  err_deg;
    logic signed [9:0]                  err_wrap;
    logic signed [hpt_pkg::SUM_W:0]     sum_wide;
    logic signed [9:0]                  delta;
    logic signed [16:0]                 gp_s;
    logic signed [16:0]                 gi_s;
    logic signed [16:0]                 gd_s;
    logic signed [25:0]                 p_prod;
    logic signed [28:0]                 i_prod;
    logic signed [26:0]                 d_prod;
    logic signed [hpt_pkg::ACC_W-1:0]   acc;
    logic signed [15:0]                 acc_clamp;
    logic signed [15:0]                 acc_adj;

    always_comb
    begin
        diff     = {target_heading[hpt_pkg::ANGLE_W-1], target_heading}
                 - {yaw[hpt_pkg::ANGLE_W-1], yaw};
        // truncate toward zero to whole degrees
        diff_adj = diff + (diff[17] ? 18'sd255 : 18'sd0);
        err_deg  = diff_adj[17:8];

        if (err_deg >= 10'(hpt_pkg::HALF_TURN))
            err_wrap = err_deg - 10'(hpt_pkg::FULL_TURN);
        else if (err_deg <= -10'(hpt_pkg::HALF_TURN))
            err_wrap = err_deg + 10'(hpt_pkg::FULL_TURN);
        else
            err_wrap = err_deg;
        prior_next = err_wrap[hpt_pkg::ERR_W-1:0];

        sum_wide = {sum_reg[hpt_pkg::SUM_W-1], sum_reg}
                 + {{(hpt_pkg::SUM_W+1-hpt_pkg::ERR_W){prior_next[hpt_pkg::ERR_W-1]}},
                    prior_next};
        if (sum_wide > 13'(hpt_pkg::SUM_LIMIT))
            sum_next = 12'(hpt_pkg::SUM_LIMIT);
        else if (sum_wide < -13'(hpt_pkg::SUM_LIMIT))
            sum_next = -12'(hpt_pkg::SUM_LIMIT);
        else
            sum_next = sum_wide[hpt_pkg::SUM_W-1:0];

        delta = {prior_next[hpt_pkg::ERR_W-1], prior_next}
              - {prior_reg[hpt_pkg::ERR_W-1], prior_reg};

        gp_s   = {1'b0, gains.p};
        gi_s   = {1'b0, gains.i};
        gd_s   = {1'b0, gains.d};
        p_prod = gp_s * prior_next;
        i_prod = gi_s * sum_next;
        d_prod = gd_s * delta;

        acc = {{4{p_prod[25]}}, p_prod}
            + {{1{i_prod[28]}}, i_prod}
            + {{3{d_prod[26]}}, d_prod};

        if (acc > 30'(hpt_pkg::DRIVE_LIMIT_Q))
            acc_clamp = 16'(hpt_pkg::DRIVE_LIMIT_Q);
        else if (acc < -30'(hpt_pkg::DRIVE_LIMIT_Q))
            acc_clamp = -16'(hpt_pkg::DRIVE_LIMIT_Q);
        else
            acc_clamp = acc[15:0];

        acc_adj = acc_clamp + (acc_clamp[15] ? 16'sd255 : 16'sd0);
        drive   = acc_adj[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg <= '0;
            sum_reg   <= '0;
        end
        else if (advance)
        begin
            prior_reg <= prior_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/heading_pid_turn.sv
// heading_pid_turn: in-place turn controller, one control tick per transaction.
// req carries target_heading and yaw (signed degrees, 8 fraction bits); rsp
// returns drive_left and drive_right (signed, -120..120, left = -right).
// Gains gain_p, gain_i, gain_d (unsigned Q8.8) are written through cfg_we,
// cfg_index and cfg_data; write them only while no tick is in flight.
// Each tick passes an input register, then one combinational pass (wrap of
// the error, clamped integral, three gain multiplies, clamp, truncate) and
// lands in the output register, which drives rsp.valid. Throughput is one
// tick per cycle while rsp.ready stays high; the integral/prior-error
// feedback is a single add and clamp, so consecutive ticks follow with no
// gap.
// When rsp.ready is low the result holds in the output register and the
// input register still takes one more tick; req.ready then drops.
// Reset clears both stages, the integral, the prior error and all gains.
`default_nettype none

module heading_pid_turn (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    hpt_in_if.sink                                 req,
    hpt_out_if.source                              rsp,
    input  wire logic                              cfg_we,
    input  wire logic [hpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hpt_pkg::GAIN_W-1:0]        cfg_data
);

    hpt_pkg::gains_t                        gains_reg;
    logic                                   in_valid_reg;
    logic signed [hpt_pkg::ANGLE_W-1:0]     target_reg;
    logic signed [hpt_pkg::ANGLE_W-1:0]     yaw_reg;
    logic                                   out_valid_reg;
    logic signed [hpt_pkg::DRIVE_W-1:0]     right_reg;
    logic signed [hpt_pkg::DRIVE_W-1:0]     left_reg;
    logic signed [hpt_pkg::DRIVE_W-1:0]     drive;
    logic                                   advance;
    logic                                   take;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.drive_left  = left_reg;
    assign rsp.drive_right = right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hpt_pkg::CFG_GAIN_P: gains_reg.p <= cfg_data;
                hpt_pkg::CFG_GAIN_I: gains_reg.i <= cfg_data;
                hpt_pkg::CFG_GAIN_D: gains_reg.d <= cfg_data;
                default:             gains_reg   <= gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            target_reg <= req.target_heading;
            yaw_reg    <= req.yaw;
        end
        if (advance)
        begin
            right_reg <= drive;
            left_reg  <= -drive;
        end
    end

    hpt_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .target_heading (target_reg),
        .yaw            (yaw_reg),
        .gains          (gains_reg),
        .drive          (drive)
    );

endmodule

`default_nettype wire

// File: rtl/hpt_check.sv
`default_nettype none

module hpt_check (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_ready,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic signed [hpt_pkg::DRIVE_W-1:0] out_left,
    input  wire logic signed [hpt_pkg::DRIVE_W-1:0] out_right
);

    // output held while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_right) && $stable(out_left))
        else $error("rsp transaction dropped or changed while stalled");

    a_drive_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_left == -out_right) && (out_right <= 8'sd120)
                      && (out_right >= -8'sd120))
        else $error("drive outputs out of range or not mirrored");

    // an empty output register never backs up the input
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("req stalled with empty output stage");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("rsp valid during reset");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid && !out_ready |=> !in_ready || out_ready)
        else $error("both stages full yet req still ready under stall");

endmodule

bind heading_pid_turn hpt_check u_hpt_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_left  (rsp.drive_left),
    .out_right (rsp.drive_right)
);

`default_nettype wire

// File: tb/sv/tb_heading_pid_turn.sv
`timescale 1ns / 1ps

module tb_heading_pid_turn;

    localparam int ONE_DEG     = 256;
    localparam int ANGLE_SPAN  = 46080;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TICKS_PER_SETTING = 100;
    localparam logic [hpt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [hpt_pkg::DRIVE_W-1:0] left;
        logic signed [hpt_pkg::DRIVE_W-1:0] right;
    } drive_pair_t;

    typedef enum int {
        BURST_NOISE,
        BURST_ONE_SIDED,
        BURST_SETTLE
    } burst_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hpt_pkg::GAIN_W-1:0] cfg_data;

    hpt_in_if  req_if ();
    hpt_out_if rsp_if ();

    heading_pid_turn dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: gains, last wrapped error, clamped integral
    int p_gain;
    int i_gain;
    int d_gain;
    int heading_err_prev;
    int heading_err_sum;

    drive_pair_t expected_drives[$];

    int src_idle_pct = 31;
    int snk_idle_pct = 86;
    int mismatches = 0;
    int ticks_sent = 0;
    int drives_checked = 0;
    int gain_settings = 0;
    int integral_clamps = 0;
    int drive_saturations = 0;
    int cycle_count = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic drive_pair_t predict_turn_drive(
        logic signed [hpt_pkg::ANGLE_W-1:0] heading,
        logic signed [hpt_pkg::ANGLE_W-1:0] yaw_meas
    );
        int diff;
        int whole_err;
        int mag;
        int err;
        longint acc;
        longint drive;
        drive_pair_t r;
        diff = int'(heading) - int'(yaw_meas);
        whole_err = diff / ONE_DEG;
        mag = (whole_err < 0) ? -whole_err : whole_err;
        if (mag >= hpt_pkg::HALF_TURN)
            err = (whole_err >= 0) ? (mag - hpt_pkg::FULL_TURN) : (hpt_pkg::FULL_TURN - mag);
        else
            err = whole_err;

        heading_err_sum = heading_err_sum + err;
        if (heading_err_sum > hpt_pkg::SUM_LIMIT || heading_err_sum < -hpt_pkg::SUM_LIMIT)
        begin
            heading_err_sum = (heading_err_sum > 0) ? hpt_pkg::SUM_LIMIT
                                                    : -hpt_pkg::SUM_LIMIT;
            integral_clamps++;
        end

        acc = longint'(p_gain) * err
            + longint'(i_gain) * heading_err_sum
            + longint'(d_gain) * (err - heading_err_prev);
        heading_err_prev = err;

        if (acc > hpt_pkg::DRIVE_LIMIT_Q || acc < -hpt_pkg::DRIVE_LIMIT_Q)
        begin
            acc = (acc > 0) ? hpt_pkg::DRIVE_LIMIT_Q : -hpt_pkg::DRIVE_LIMIT_Q;
            drive_saturations++;
        end
        drive = acc / ONE_DEG;
        r.right = drive[hpt_pkg::DRIVE_W-1:0];
        r.left  = -r.right;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_tick(input int heading_q8, input int yaw_q8);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.target_heading <= heading_q8[hpt_pkg::ANGLE_W-1:0];
        req_if.yaw <= yaw_q8[hpt_pkg::ANGLE_W-1:0];
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        expected_drives.push_back(
            predict_turn_drive(heading_q8[hpt_pkg::ANGLE_W-1:0],
                               yaw_q8[hpt_pkg::ANGLE_W-1:0]));
        ticks_sent++;
    endtask

    // drop valid and let the pipeline empty
    task automatic wait_drain();
        req_if.valid <= 1'b0;
        while (expected_drives.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_gains(input int p, input int i, input int d);
        int spare_data;
        spare_data = $urandom;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= hpt_pkg::CFG_GAIN_P;
        cfg_data <= p[hpt_pkg::GAIN_W-1:0];
        @(posedge clk);
        cfg_index <= hpt_pkg::CFG_GAIN_I;
        cfg_data <= i[hpt_pkg::GAIN_W-1:0];
        @(posedge clk);
        cfg_index <= hpt_pkg::CFG_GAIN_D;
        cfg_data <= d[hpt_pkg::GAIN_W-1:0];
        @(posedge clk);
        // write to the spare index must leave every gain alone
        cfg_index <= CFG_UNUSED;
        cfg_data <= spare_data[hpt_pkg::GAIN_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        p_gain = p;
        i_gain = i;
        d_gain = d;
        gain_settings++;
    endtask

    task automatic test_zero_gains();
        send_tick(0, 0);
        send_tick(ANGLE_SPAN, -ANGLE_SPAN);
        send_tick(-179 * ONE_DEG, 0);
        wait_drain();
    endtask

    task automatic test_wrap_and_limits();
        load_gains(16'h0100, 16'h0004, 16'h0040);
        send_tick(180 * ONE_DEG, 0);
        send_tick(0, 180 * ONE_DEG);
        send_tick(179 * ONE_DEG, 0);
        send_tick(-179 * ONE_DEG, 0);
        // fractions truncate toward zero
        send_tick(255, 0);
        send_tick(-255, 0);
        send_tick(-ONE_DEG, 0);
        send_tick(ANGLE_SPAN, -ANGLE_SPAN);
        send_tick(-ANGLE_SPAN, ANGLE_SPAN);
        // full 17-bit values outside the stated angle range
        send_tick(65535, -65536);
        send_tick(-65536, 65535);
        send_tick(181 * ONE_DEG + 100, 0);
        wait_drain();
    endtask

    task automatic test_integral_clamp();
        load_gains(16'h0000, 16'h0020, 16'h0000);
        repeat (8) send_tick(170 * ONE_DEG, 0);
        repeat (3) send_tick(0, 100 * ONE_DEG);
        wait_drain();
    endtask

    task automatic send_burst(input int n);
        burst_kind_t kind;
        int side;
        int base;
        int yw;
        kind = burst_kind_t'($urandom_range(2));
        side = ($urandom_range(1) == 1) ? 1 : -1;
        base = int'($urandom_range(2 * ANGLE_SPAN)) - ANGLE_SPAN;
        for (int k = 0; k < n; k++)
        begin
            case (kind)
                BURST_NOISE:
                    send_tick(int'($urandom), int'($urandom));
                BURST_ONE_SIDED:
                begin
                    // same-sign error every tick pushes the integral to its limit
                    yw = int'($urandom_range(2 * ANGLE_SPAN)) - ANGLE_SPAN;
                    send_tick(yw + side * int'($urandom_range(179 * ONE_DEG, ONE_DEG)),
                              yw);
                end
                default:
                    send_tick(base, base + int'($urandom_range(10 * ONE_DEG)) - 5 * ONE_DEG);
            endcase
        end
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct);
        int left;
        int n;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int s = 0; s < 4; s++)
        begin
            case (s)
                0: load_gains($urandom_range(65535), $urandom_range(65535),
                              $urandom_range(65535));
                1: load_gains(65535, 65535, 65535);
                2: load_gains($urandom_range(16'h0800), $urandom_range(16'h0040),
                              $urandom_range(16'h0400));
                default: load_gains(0, $urandom_range(16'h0100), 65535);
            endcase
            left = TICKS_PER_SETTING;
            while (left > 0)
            begin
                n = $urandom_range(20, 1);
                if (n > left)
                    n = left;
                send_burst(n);
                left -= n;
            end
            wait_drain();
        end
    endtask

    always @(posedge clk)
    begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        drive_pair_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_drives.size() == 0)
                report_mismatch($sformatf("unexpected result left=%0d right=%0d",
                                          rsp_if.drive_left, rsp_if.drive_right));
            else
            begin
                want = expected_drives.pop_front();
                if (rsp_if.drive_left !== want.left)
                    report_mismatch($sformatf("drive_left got %0d want %0d",
                                              rsp_if.drive_left, want.left));
                if (rsp_if.drive_right !== want.right)
                    report_mismatch($sformatf("drive_right got %0d want %0d",
                                              rsp_if.drive_right, want.right));
                drives_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_drives.size());
            $display("** heading_pid_turn: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = hpt_pkg::CFG_GAIN_P;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.target_heading = '0;
        req_if.yaw = '0;
        rsp_if.ready = 1'b0;
        p_gain = 0;
        i_gain = 0;
        d_gain = 0;
        heading_err_prev = 0;
        heading_err_sum = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_gains();
        test_wrap_and_limits();
        test_integral_clamp();
        test_random_traffic(31, 86);
        test_random_traffic(86, 31);
        test_random_traffic(0, 0);

        wait_drain();
        $display("Sent %0d control ticks across %0d gain settings, checked %0d drive pairs",
                 ticks_sent, gain_settings, drives_checked);
        $display("Integral hit its limit %0d times, drive saturated %0d times, %0d mismatches",
                 integral_clamps, drive_saturations, mismatches);
        if (mismatches == 0 && expected_drives.size() == 0)
            $display("** heading_pid_turn: PASSED **");
        else
            $display("** heading_pid_turn: FAILED **");
        $finish;
    end

endmodule
